FILE: rtl/core/tofw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofw_pkg
// Shared constants and types for the time-of-flight window photon summer.
// ----------------------------------------------------------------------------
package tofw_pkg;

	localparam int NUM_WINDOWS = 10;

	localparam int TIME_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int SUM_W    = 16;
	localparam int WIDTH_W  = 12;
	localparam int INDEX_W  = 4;

	// Window edge (l+1)*width, and the signed compare width for the dark test.
	localparam int STEP_W = WIDTH_W + $clog2(NUM_WINDOWS + 1);
	localparam int CMP_W  = ((STEP_W > TIME_W) ? STEP_W : TIME_W) + 3;

	localparam int CNT_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

	// Input kind codes.
	localparam logic KIND_HIT = 1'b0;
	localparam logic KIND_EOE = 1'b1;

	// Register indexes.
	localparam logic REG_WINDOW_WIDTH = 1'b0;
	localparam logic REG_DARK_START   = 1'b1;

	typedef struct packed {
		logic [NUM_WINDOWS-1:0] sig_add;
		logic [NUM_WINDOWS-1:0] dark_add;
	} tofw_mask_t;

endpackage

FILE: rtl/core/tofw_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofw_classify
// Find the first window whose signal or dark test passes and build the
// per-counter add masks from that index upward.
// ----------------------------------------------------------------------------
module tofw_classify (
	input  logic signed [tofw_pkg::TIME_W-1:0]  tof_time,
	input  logic        [tofw_pkg::WIDTH_W-1:0] window_width,
	input  logic signed [tofw_pkg::TIME_W-1:0]  dark_start,
	output tofw_pkg::tofw_mask_t                mask
);
	import tofw_pkg::*;

	logic [TIME_W:0]              abs_t;
	logic signed [CMP_W-1:0]      t_ext;
	logic signed [CMP_W-1:0]      lo_ext;
	logic [NUM_WINDOWS-1:0]       sig_pass;
	logic [NUM_WINDOWS-1:0]       dark_pass;

	always_comb begin
		logic [STEP_W-1:0]       step;
		logic signed [CMP_W-1:0] hi;
		logic                    found;
		logic                    sig_on;
		logic                    dark_on;

		t_ext  = CMP_W'(tof_time);
		lo_ext = CMP_W'(dark_start);
		abs_t  = tof_time[TIME_W-1] ? (TIME_W+1)'(-t_ext) : (TIME_W+1)'(t_ext);

		// Independent edge tests per window.
		for (int l = 0; l < NUM_WINDOWS; l++) begin
			step = STEP_W'(STEP_W'(l + 1) * STEP_W'(window_width));
			hi   = lo_ext + signed'(CMP_W'({step, 1'b0}));
			sig_pass[l]  = STEP_W'(abs_t) < step && (TIME_W+1 <= STEP_W || abs_t <
				(TIME_W+1)'(step));
			dark_pass[l] = (lo_ext < t_ext) && (t_ext < hi);
		end

		// First passing test wins; signal test ahead of dark at each index.
		found   = 1'b0;
		sig_on  = 1'b0;
		dark_on = 1'b0;
		for (int l = 0; l < NUM_WINDOWS; l++) begin
			if (!found && sig_pass[l]) begin
				sig_on = 1'b1;
				found  = 1'b1;
			end else if (!found && dark_pass[l]) begin
				dark_on = 1'b1;
				found   = 1'b1;
			end
			mask.sig_add[l]  = sig_on;
			mask.dark_add[l] = dark_on;
		end
	end

endmodule

FILE: rtl/core/tof_window_photon_summer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_window_photon_summer_top
// Nested time-window photon summer: hits add their photon count to signal or
// dark window sums, an end-of-event request reports and clears all sums.
// ----------------------------------------------------------------------------
// Path: a hit lands in the sums in the cycle after acceptance; an end-of-event
//   request's first report passes the snapshot and the output register.
// Throughput: one hit per cycle; an end-of-event request emits NUM_WINDOWS
//   reports from a snapshot shift line, one per cycle unless m_tready is low;
//   a second end-of-event request waits in the input stage until they drain.
// Reset: arst_n clears all sums, the pipeline and the report logic, and loads
//   window_width = 64, dark_start = 1280.
// ----------------------------------------------------------------------------
module tof_window_photon_summer_top (
	input  logic        clk,
	input  logic        arst_n,

	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] tof_time, [23:16] photon_count
	input  logic [0:0]  s_tuser,   // [0] kind

	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] window_index, [19:4] signal_sum,
	                               // [35:20] dark_sum, [39:36] zero
	output logic        m_tlast,   // last

	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tofw_pkg::*;

	// Configuration registers
	logic [WIDTH_W-1:0]       window_width_q;
	logic signed [TIME_W-1:0] dark_start_q;

	// Input stage
	logic                     valid_s1;
	logic                     kind_s1;
	logic signed [TIME_W-1:0] time_s1;
	logic [COUNT_W-1:0]       count_s1;
	logic                     go_s1;

	// Running sums
	logic [SUM_W-1:0] sig_tot_q  [NUM_WINDOWS];
	logic [SUM_W-1:0] dark_tot_q [NUM_WINDOWS];

	// Report snapshot and sequencing
	logic [SUM_W-1:0] rep_sig_q  [NUM_WINDOWS];
	logic [SUM_W-1:0] rep_dark_q [NUM_WINDOWS];
	logic             rep_active_q;
	logic [CNT_W-1:0] rep_cnt_q;
	logic             out_load;

	// Output register
	logic               m_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [SUM_W-1:0]   out_sig_q;
	logic [SUM_W-1:0]   out_dark_q;
	logic               out_last_q;

	logic [31:0] cnt_ext;
	logic        cfg_write;
	tofw_mask_t  mask;

	// ---------------------------------------------------------------- config
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q <= WIDTH_W'(64);
			dark_start_q   <= TIME_W'(1280);
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_WINDOW_WIDTH: window_width_q <= pwdata[WIDTH_W-1:0];
				REG_DARK_START:   dark_start_q   <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_WIDTH: prdata = 32'(window_width_q);
			REG_DARK_START:   prdata = 32'(unsigned'(dark_start_q));
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ input stage
	// A hit always moves on; an end-of-event request holds while a report runs.
	assign go_s1    = valid_s1 && (kind_s1 == KIND_HIT || !rep_active_q);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser[0];
			time_s1  <= s_tdata[15:0];
			count_s1 <= s_tdata[23:16];
		end
	end

	// --------------------------------------------------------- classification
	tofw_classify u_classify (
		.tof_time     (time_s1),
		.window_width (window_width_q),
		.dark_start   (dark_start_q),
		.mask         (mask)
	);

	// ------------------------------------------------------------ accumulate
	// Saturating add of the photon count into every flagged counter; an
	// end-of-event request snapshots the sums and clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_WINDOWS; m++) begin
				sig_tot_q[m]  <= '0;
				dark_tot_q[m] <= '0;
			end
		end else if (go_s1) begin
			for (int m = 0; m < NUM_WINDOWS; m++) begin
				logic [SUM_W:0] s_sum;
				logic [SUM_W:0] d_sum;
				s_sum = {1'b0, sig_tot_q[m]}  + (SUM_W+1)'(count_s1);
				d_sum = {1'b0, dark_tot_q[m]} + (SUM_W+1)'(count_s1);
				if (kind_s1 == KIND_EOE) begin
					sig_tot_q[m]  <= '0;
					dark_tot_q[m] <= '0;
				end else begin
					if (mask.sig_add[m])
						sig_tot_q[m] <= s_sum[SUM_W] ? '1 : s_sum[SUM_W-1:0];
					if (mask.dark_add[m])
						dark_tot_q[m] <= d_sum[SUM_W] ? '1 : d_sum[SUM_W-1:0];
				end
			end
		end
	end

	// ---------------------------------------------------------------- report
	assign out_load = rep_active_q && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_active_q <= 1'b0;
			rep_cnt_q    <= '0;
		end else if (go_s1 && kind_s1 == KIND_EOE) begin
			rep_active_q <= 1'b1;
			rep_cnt_q    <= '0;
		end else if (out_load) begin
			if (rep_cnt_q == CNT_W'(NUM_WINDOWS - 1)) begin
				rep_active_q <= 1'b0;
			end
			rep_cnt_q <= rep_cnt_q + CNT_W'(1);
		end
	end

	// Snapshot on end of event, then advance one entry per emitted report.
	always_ff @(posedge clk) begin
		if (go_s1 && kind_s1 == KIND_EOE) begin
			for (int m = 0; m < NUM_WINDOWS; m++) begin
				rep_sig_q[m]  <= sig_tot_q[m];
				rep_dark_q[m] <= dark_tot_q[m];
			end
		end else if (out_load) begin
			for (int m = 0; m < NUM_WINDOWS - 1; m++) begin
				rep_sig_q[m]  <= rep_sig_q[m+1];
				rep_dark_q[m] <= rep_dark_q[m+1];
			end
		end
	end

	// ------------------------------------------------------- output register
	assign cnt_ext = 32'(rep_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= cnt_ext[INDEX_W-1:0];
			out_sig_q   <= rep_sig_q[0];
			out_dark_q  <= rep_dark_q[0];
			out_last_q  <= (rep_cnt_q == CNT_W'(NUM_WINDOWS - 1));
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, out_dark_q, out_sig_q, out_index_q};
	assign m_tlast  = out_last_q;

endmodule
